/* rtl/cfir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_pkg: shared constants, types and tap tables
// Sizes, coefficient tables and the sequencer state type of the crossfaded
// multichannel FIR core.
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int TAP_COUNT    = 21;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;

    localparam int TABLE_LEN  = 21;
    localparam int TBL_IDX_W  = 5;
    localparam int COEF_W     = 12;
    localparam int DIFF_W     = 13;
    localparam int FRAC_BITS  = 15;
    localparam int MIX_BITS   = 8;
    localparam int MIX_W      = 9;
    localparam int CNT_W      = 4;
    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam int MIX_ONE    = 1 << MIX_BITS;
    localparam int HIST_DEPTH = MAX_CHANNELS * TAP_COUNT;
    localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SLOT_W     = $clog2(TAP_COUNT);
    localparam int CH_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int W_W        = COEF_W + MIX_BITS + 1;
    localparam int PROD_W     = SAMPLE_BITS + W_W;
    localparam int ACC_W      = PROD_W + $clog2(TAP_COUNT) + 1;
    localparam int RND_SH     = FRAC_BITS + MIX_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_MIX_FACTOR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

    localparam logic [MIX_W-1:0] MIX_RESET   = MIX_W'(MIX_ONE);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    localparam logic signed [COEF_W-1:0] TAPS_FIRST [TABLE_LEN] = '{
        -12'sd114, 12'sd16, 12'sd151, 12'sd286, 12'sd416, 12'sd536, 12'sd641,
        12'sd728, 12'sd792, 12'sd832, 12'sd846, 12'sd832, 12'sd792, 12'sd728,
        12'sd641, 12'sd536, 12'sd416, 12'sd286, 12'sd151, 12'sd16, -12'sd114
    };

    localparam logic signed [COEF_W-1:0] TAPS_SECOND [TABLE_LEN] = '{
        -12'sd626, -12'sd828, -12'sd909, -12'sd850, -12'sd657, -12'sd356,
        12'sd8, 12'sd379, 12'sd696, 12'sd910, 12'sd986, 12'sd910, 12'sd696,
        12'sd379, 12'sd8, -12'sd356, -12'sd657, -12'sd850, -12'sd909,
        -12'sd828, -12'sd626
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Taps past the end of the table are zero.
    function automatic logic signed [COEF_W-1:0] tap_first(
        input logic [SLOT_W-1:0] idx
    );
        logic signed [COEF_W-1:0] val;
        val = '0;
        if (int'(idx) < TABLE_LEN) begin
            val = TAPS_FIRST[TBL_IDX_W'(idx)];
        end
        return val;
    endfunction

    function automatic logic signed [DIFF_W-1:0] tap_delta(
        input logic [SLOT_W-1:0] idx
    );
        logic signed [DIFF_W-1:0] val;
        val = '0;
        if (int'(idx) < TABLE_LEN) begin
            val = DIFF_W'(TAPS_SECOND[TBL_IDX_W'(idx)]) - DIFF_W'(TAPS_FIRST[TBL_IDX_W'(idx)]);
        end
        return val;
    endfunction

endpackage
`default_nettype wire

/* rtl/crossfaded_fir_multichannel_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crossfaded_fir_multichannel_core: multichannel FIR with crossfaded taps
// Interleaved samples tagged by channel enter on the slave stream. Each
// channel keeps a private history, and each request returns one filtered
// sample on the master stream. The taps blend two fixed sets by the mix
// register.
//
// Usage: both streams carry the sample in tdata, the channel in tuser and the
// block-end mark in tlast. Registers are written through the cfg port, and the
// user must write them only while the core is idle; the core does not enforce
// it. s_axis_tready is high only when the core is idle. A request for an active
// channel makes one history write, then passes one tap per cycle through the
// shared multiply-accumulate unit, then drains its pipeline and saturates. An
// unused channel returns a zero sample in the cycle after acceptance. The
// result waits in the output register while m_axis_tready is low, and no new
// request is taken until it has been delivered. Reset clears the histories
// through per-entry valid bits, zeroes the write slots, and restores the mix
// factor to 256 and the channel count to 2.
// ----------------------------------------------------------------------------
module crossfaded_fir_multichannel_core
    import cfir_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  signed [SAMPLE_BITS-1:0] s_axis_tdata,  // sample_in
    input  wire  [CH_W-1:0]               s_axis_tuser,  // channel
    input  wire                           s_axis_tlast,  // block_end
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic signed [SAMPLE_BITS-1:0] m_axis_tdata,  // sample_out
    output logic [CH_W-1:0]               m_axis_tuser,  // out_channel
    output logic                          m_axis_tlast,  // out_block_end
    input  wire                           i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]         i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [MIX_W-1:0]              r_mix;
    logic [CNT_W-1:0]              r_count;
    logic [SLOT_W-1:0]             r_slot [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_hist [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]         r_hvalid;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [CH_W-1:0]               r_ch;
    logic                          r_last;
    logic [ADDR_W-1:0]             r_base;
    logic [SLOT_W-1:0]             r_pos;
    logic [SLOT_W-1:0]             r_idx;

    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic                          r_rd_ok;
    logic signed [W_W-1:0]         r_w;
    logic                          r_s1;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_s2;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [SAMPLE_BITS-1:0] r_result;

    logic                          s_acc_go;
    logic                          s_in_use;
    logic                          s_mem_we;
    logic                          s_issue;
    logic [CH_IDX_W-1:0]           s_ch_idx;
    logic [SLOT_W-1:0]             s_cur_slot;
    logic [CNT_W-1:0]              s_used;
    logic [MIX_W-1:0]              s_x;
    logic [ADDR_W-1:0]             s_addr;
    logic signed [MIX_W:0]         s_x_s;
    logic signed [MIX_W+DIFF_W:0]  s_mix_prod;
    logic signed [W_W-1:0]         s_weight;
    logic signed [SAMPLE_BITS-1:0] s_rd_val;
    logic signed [ACC_W-1:0]       s_rounded;
    logic signed [ACC_W-1:0]       s_shifted;
    logic signed [SAMPLE_BITS-1:0] s_sat;

    assign s_acc_go   = s_axis_tvalid && s_axis_tready;
    assign s_ch_idx   = CH_IDX_W'(s_axis_tuser);
    assign s_cur_slot = r_slot[s_ch_idx];
    assign s_used     = (r_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : r_count;
    assign s_in_use   = (CNT_W'(s_axis_tuser) < s_used);
    assign s_x        = (r_mix > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : r_mix;
    assign s_addr     = r_base + ADDR_W'(r_pos);

    assign s_x_s      = $signed({1'b0, s_x});
    assign s_mix_prod = s_x_s * tap_delta(r_idx);
    assign s_weight   = (W_W'(tap_first(r_idx)) <<< MIX_BITS) + W_W'(s_mix_prod);
    assign s_rd_val   = r_rd_ok ? r_rd_data : '0;

    assign s_rounded  = r_acc + (ACC_W'(1) <<< (RND_SH - 1));
    assign s_shifted  = s_rounded >>> RND_SH;

    always_comb begin
        if (s_shifted > ACC_W'((1 << (SAMPLE_BITS - 1)) - 1)) begin
            s_sat = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        end else if (s_shifted < -ACC_W'(1 << (SAMPLE_BITS - 1))) begin
            s_sat = SAMPLE_BITS'(-(1 << (SAMPLE_BITS - 1)));
        end else begin
            s_sat = SAMPLE_BITS'(s_shifted);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc_go) begin
                    n_state = s_in_use ? ST_WRITE : ST_OUT;
                end
            end
            ST_WRITE: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_idx == SLOT_W'(TAP_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1 && !r_s2) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        s_mem_we      = 1'b0;
        s_issue       = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_WRITE: s_mem_we      = 1'b1;
            ST_RUN:   s_issue       = 1'b1;
            ST_OUT:   m_axis_tvalid = 1'b1;
            default:  s_issue       = 1'b0;
        endcase
    end

    assign m_axis_tdata = r_result;
    assign m_axis_tuser = r_ch;
    assign m_axis_tlast = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mix    <= MIX_RESET;
            r_count  <= COUNT_RESET;
            r_hvalid <= '0;
            r_s1     <= 1'b0;
            r_s2     <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_slot[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_s1    <= s_issue;
            r_s2    <= r_s1;
            if (i_cfg_we && i_cfg_index == CFG_MIX_FACTOR) begin
                r_mix <= MIX_W'(i_cfg_data);
            end
            if (i_cfg_we && i_cfg_index == CFG_CHANNEL_COUNT) begin
                r_count <= CNT_W'(i_cfg_data);
            end
            if (s_mem_we) begin
                r_hvalid[s_addr] <= 1'b1;
                r_slot[CH_IDX_W'(r_ch)] <= (r_pos == SLOT_W'(TAP_COUNT - 1)) ? '0
                                                                             : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_mem_we) begin
            r_hist[s_addr] <= r_sample;
        end
        r_rd_data <= r_hist[s_addr];
        r_rd_ok   <= r_hvalid[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_acc_go) begin
            r_sample <= s_axis_tdata;
            r_ch     <= s_axis_tuser;
            r_last   <= s_axis_tlast;
            r_base   <= ADDR_W'(s_ch_idx) * ADDR_W'(TAP_COUNT);
            r_pos    <= s_cur_slot;
            r_idx    <= '0;
            r_acc    <= '0;
            r_result <= '0;
        end
        if (s_issue) begin
            r_idx <= r_idx + 1'b1;
            r_pos <= (r_pos == '0) ? SLOT_W'(TAP_COUNT - 1) : r_pos - 1'b1;
        end
        r_w    <= s_weight;
        r_prod <= s_rd_val * r_w;
        if (r_s2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == ST_DRAIN && !r_s1 && !r_s2) begin
            r_result <= s_sat;
        end
    end

`ifndef SYNTHESIS
    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1 |=> r_s2)
        else $error("multiply stage did not follow the read stage");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1 && !r_s2))
        else $error("pipeline busy while idle");

    a_used_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc_go && s_in_use) |=> (r_state == ST_WRITE))
        else $error("active channel request did not write its history");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc_go |-> (s_cur_slot < SLOT_W'(TAP_COUNT)))
        else $error("write slot out of range");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the crossfaded multichannel FIR core
// A directed table runs first: reset state, full-scale samples, idle channels,
// mix and channel-count extremes and out-of-range register values. Random
// phases follow, each with fresh register settings. A bench-side filter with
// its own per-channel history predicts every result but those of the directed
// steps with a typed expected value. Both stream sides stall in random bursts
// until the final phases.
module tb_top;
    import cfir_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_W-1:0]               chan;
        logic                          last;
    } t_filtered;

    typedef struct {
        logic                          is_cfg;
        logic [CFG_IDX_W-1:0]          reg_sel;
        logic [CFG_DATA_W-1:0]         reg_val;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_W-1:0]               chan;
        logic                          last;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] typed_out;
    } t_step;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic signed [SAMPLE_BITS-1:0] s_axis_tdata;   // sample_in
    logic [CH_W-1:0]               s_axis_tuser;   // channel
    logic                          s_axis_tlast;   // block_end
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic signed [SAMPLE_BITS-1:0] m_axis_tdata;   // sample_out
    logic [CH_W-1:0]               m_axis_tuser;   // out_channel
    logic                          m_axis_tlast;   // out_block_end
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    logic signed [SAMPLE_BITS-1:0] chan_hist [MAX_CHANNELS][TAP_COUNT];
    int          chan_slot [MAX_CHANNELS];
    int          mix_reg;
    int          count_reg;
    t_filtered   pending_outputs [$];
    t_step       directed_steps [23];
    bit          idling_on;
    int          error_count;
    int          requests_sent;
    int          results_checked;
    int          cfg_writes;
    int          idle_channel_hits;

    crossfaded_fir_multichannel_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // For a channel in use, writes the sample into its history and returns the filtered output; others return zero.
    function automatic t_filtered filter_sample(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [CH_W-1:0]               chan,
        input logic                          last
    );
        t_filtered res;
        int        used;
        int        x;
        int        slot;
        int        pos;
        int        i;
        longint    w;
        longint    acc;
        longint    y;
        used = (count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg;
        x = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
        res.smp = '0;
        res.chan = chan;
        res.last = last;
        if (int'(chan) < used) begin
            slot = chan_slot[chan];
            chan_hist[chan][slot] = smp;
            acc = 0;
            for (i = 0; i < TAP_COUNT && i < TABLE_LEN; i++) begin
                pos = (slot + TAP_COUNT - i) % TAP_COUNT;
                w = longint'(MIX_ONE - x) * longint'(TAPS_FIRST[i])
                  + longint'(x) * longint'(TAPS_SECOND[i]);
                acc += longint'(chan_hist[chan][pos]) * w;
            end
            y = (acc + (longint'(1) <<< 22)) >>> 23;
            if (y > 32767) begin
                y = 32767;
            end
            if (y < -32768) begin
                y = -32768;
            end
            res.smp = y[SAMPLE_BITS-1:0];
            chan_slot[chan] = (slot + 1) % TAP_COUNT;
        end else begin
            idle_channel_hits++;
        end
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_request(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [CH_W-1:0]               chan,
        input logic                          last,
        input logic                          typed,
        input logic signed [SAMPLE_BITS-1:0] typed_out
    );
        t_filtered res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= chan;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        res = filter_sample(smp, chan, last);
        if (typed) begin
            res.smp = typed_out;
        end
        pending_outputs.push_back(res);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    // Registers change only once the core has drained every request.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  sel,
        input logic [CFG_DATA_W-1:0] val
    );
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        if (sel == CFG_MIX_FACTOR) begin
            mix_reg = int'(val[MIX_W-1:0]);
        end else if (sel == CFG_CHANNEL_COUNT) begin
            count_reg = int'(val[CNT_W-1:0]);
        end
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : receiver
        int hold;
        bit rdy;
        hold = 0;
        rdy = 1'b1;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                if (idling_on && $urandom_range(0, 2) == 0) begin
                    rdy = 1'b0;
                    hold = $urandom_range(1, 9);
                end else begin
                    rdy = 1'b1;
                    hold = $urandom_range(1, 16);
                end
            end
            m_axis_tready <= rdy;
            hold--;
        end
    end

    always @(posedge i_clk) begin : check_output
        t_filtered want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: sample_out %0d out_channel %0d",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (m_axis_tdata !== want.smp) begin
                    $error("sample_out: expected %0d, got %0d", want.smp, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.chan) begin
                    $error("out_channel: expected %0d, got %0d", want.chan, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("out_block_end: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int                            phase;
        int                            k;
        int                            used;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_W-1:0]               chan;
        logic [MIX_W-1:0]              mix_val;
        logic [CNT_W-1:0]              count_val;
        directed_steps = '{
            '{1'b0, '0, '0, 16'sd0,      3'd0, 1'b0, 1'b1, 16'sd0},
            '{1'b0, '0, '0, 16'sh7FFF,   3'd1, 1'b0, 1'b1, -16'sd626},
            '{1'b0, '0, '0, 16'sh8000,   3'd7, 1'b1, 1'b1, 16'sd0},
            '{1'b0, '0, '0, 16'sd12345,  3'd2, 1'b0, 1'b1, 16'sd0},
            '{1'b0, '0, '0, 16'sh8000,   3'd0, 1'b1, 1'b0, '0},
            '{1'b1, CFG_MIX_FACTOR, 9'd0, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh8000,   3'd1, 1'b0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh7FFF,   3'd0, 1'b1, 1'b0, '0},
            '{1'b1, CFG_MIX_FACTOR, 9'h1FF, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh5A5A,   3'd0, 1'b0, 1'b0, '0},
            '{1'b0, '0, '0, -16'sd1,     3'd1, 1'b1, 1'b0, '0},
            '{1'b1, CFG_CHANNEL_COUNT, 9'd8, '0, '0, '0, 1'b0, '0},
            '{1'b1, CFG_MIX_FACTOR, 9'd128, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh7FFF,   3'd7, 1'b1, 1'b0, '0},
            '{1'b0, '0, '0, 16'sd1,      3'd5, 1'b0, 1'b0, '0},
            '{1'b1, CFG_CHANNEL_COUNT, 9'h1FF, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh8000,   3'd7, 1'b0, 1'b0, '0},
            '{1'b1, CFG_CHANNEL_COUNT, 9'd0, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh7FFF,   3'd0, 1'b1, 1'b1, 16'sd0},
            '{1'b1, CFG_CHANNEL_COUNT, 9'd1, '0, '0, '0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh8000,   3'd0, 1'b0, 1'b0, '0},
            '{1'b0, '0, '0, 16'sh7FFF,   3'd1, 1'b0, 1'b1, 16'sd0},
            '{1'b0, '0, '0, 16'sh8000,   3'd4, 1'b1, 1'b1, 16'sd0}
        };
        for (k = 0; k < MAX_CHANNELS; k++) begin
            chan_slot[k] = 0;
            for (phase = 0; phase < TAP_COUNT; phase++) begin
                chan_hist[k][phase] = '0;
            end
        end
        mix_reg = MIX_ONE;
        count_reg = 2;
        idling_on = 1'b1;
        error_count = 0;
        requests_sent = 0;
        results_checked = 0;
        cfg_writes = 0;
        idle_channel_hits = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                write_register(directed_steps[k].reg_sel, directed_steps[k].reg_val);
            end else begin
                drive_request(directed_steps[k].smp, directed_steps[k].chan,
                              directed_steps[k].last, directed_steps[k].typed,
                              directed_steps[k].typed_out);
                sender_gap();
            end
        end

        for (phase = 0; phase < 15; phase++) begin
            idling_on = (phase < 12);
            case ($urandom_range(0, 5))
                0: mix_val = '0;
                1: mix_val = MIX_W'(MIX_ONE);
                2: mix_val = MIX_W'($urandom_range(MIX_ONE + 1, 511));
                default: mix_val = MIX_W'($urandom_range(0, MIX_ONE));
            endcase
            case ($urandom_range(0, 7))
                0: count_val = '0;
                1: count_val = CNT_W'($urandom_range(MAX_CHANNELS + 1, 15));
                2: count_val = CNT_W'(MAX_CHANNELS);
                3: count_val = CNT_W'(1);
                default: count_val = CNT_W'($urandom_range(1, MAX_CHANNELS));
            endcase
            write_register(CFG_MIX_FACTOR, CFG_DATA_W'(mix_val));
            write_register(CFG_CHANNEL_COUNT,
                           {5'($urandom_range(0, 31)), count_val});
            used = (count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg;
            for (k = 0; k < 50; k++) begin
                case ($urandom_range(0, 9))
                    0: smp = 16'sh7FFF;
                    1: smp = 16'sh8000;
                    2: smp = SAMPLE_BITS'($signed($urandom_range(0, 255)) - 128);
                    default: smp = SAMPLE_BITS'($urandom);
                endcase
                if (used > 0 && $urandom_range(0, 19) > 2) begin
                    chan = CH_W'($urandom_range(0, used - 1));
                end else begin
                    chan = CH_W'($urandom_range(0, MAX_CHANNELS - 1));
                end
                drive_request(smp, chan, ($urandom_range(0, 7) == 0), 1'b0, '0);
                sender_gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests (%0d on channels outside the active count), checked %0d results.",
                 requests_sent, idle_channel_hits, results_checked);
        $display("Ran %0d register writes across mix and channel-count extremes.", cfg_writes);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
